### rtl/sll_pkg.sv
// Package with widths, opcodes, status codes and payload types of the linked list engine.
package sll_pkg;
    localparam int POOL_SIZE = 256;
    localparam int AW = $clog2(POOL_SIZE);
    localparam int CW = AW + 1;
    localparam int DATA_WIDTH = 32;

    localparam logic [3:0] OP_CREATE  = 4'd0;
    localparam logic [3:0] OP_DESTROY = 4'd1;
    localparam logic [3:0] OP_EMPTY   = 4'd2;
    localparam logic [3:0] OP_LENGTH  = 4'd3;
    localparam logic [3:0] OP_GET     = 4'd4;
    localparam logic [3:0] OP_LOCATE  = 4'd5;
    localparam logic [3:0] OP_PRIOR   = 4'd6;
    localparam logic [3:0] OP_NEXT    = 4'd7;
    localparam logic [3:0] OP_INSERT  = 4'd8;
    localparam logic [3:0] OP_DELETE  = 4'd9;
    localparam logic [3:0] OP_FREECNT = 4'd10;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ERR  = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic [3:0]            opcode;
        logic [7:0]            list_head;
        logic [8:0]            position;
        logic [DATA_WIDTH-1:0] data_in;
    } t_cmd;

    typedef struct packed {
        logic [1:0]            status;
        logic [7:0]            new_head;
        logic [8:0]            count_out;
        logic [DATA_WIDTH-1:0] data_out;
    } t_rsp;
endpackage

### rtl/sll_if.sv
// Valid/ready channel interfaces for command requests and result requests.
interface sll_cmd_if;
    import sll_pkg::*;
    logic valid;
    logic ready;
    t_cmd payload;
    modport source(output valid, output payload, input ready);
    modport sink(input valid, input payload, output ready);
endinterface

interface sll_rsp_if;
    import sll_pkg::*;
    logic valid;
    logic ready;
    t_rsp payload;
    modport source(output valid, output payload, input ready);
    modport sink(input valid, input payload, output ready);
endinterface

### rtl/static_linked_list_engine_core.sv
// Linked list engine top: command sequencer over link and value memories.
// Length and free count follow the chain one link read at a time; element walks read the link
// and then the value of each element visited; prior and next read one more value, delete relinks.
// Insert links a free node in at position p; destroy frees every node; a rejected one goes to done.
// Throughput: one command at a time; the next is accepted while the previous result waits.
// Reset: synchronous active low; a clearing pass over all POOL_SIZE nodes chains the free list first.
module static_linked_list_engine_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    sll_cmd_if.sink      i_cmd,
    sll_rsp_if.source    o_rsp
);
    import sll_pkg::*;

    localparam logic [3:0] S_INIT  = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_RD    = 4'd2;
    localparam logic [3:0] S_WAIT  = 4'd3;
    localparam logic [3:0] S_STEP  = 4'd4;
    localparam logic [3:0] S_VRD   = 4'd5;
    localparam logic [3:0] S_VCHK  = 4'd6;
    localparam logic [3:0] S_TAKE  = 4'd7;
    localparam logic [3:0] S_TAKEW = 4'd8;
    localparam logic [3:0] S_WR1   = 4'd9;
    localparam logic [3:0] S_WR2   = 4'd10;
    localparam logic [3:0] S_DONE  = 4'd11;
    localparam logic [3:0] S_FREE  = 4'd12;

    logic [3:0] r_state;
    t_cmd r_cmd;
    logic [AW-1:0] r_cur, r_prev, r_tmp, r_free;
    logic [CW-1:0] r_cnt, r_steps;
    logic [1:0] r_phase;
    t_rsp r_rsp;
    t_rsp r_out;
    logic r_ovalid;

    // Link memory port.
    logic l_we;
    logic [AW-1:0] l_addr, l_wdata, l_rdata;
    // Value memory port.
    logic v_we;
    logic [AW-1:0] v_addr;
    logic [DATA_WIDTH-1:0] v_wdata, v_rdata;

    sll_ram #(.DEPTH(POOL_SIZE), .WIDTH(AW)) u_links (
        .i_clk(i_clk), .i_we(l_we), .i_addr(l_addr), .i_wdata(l_wdata), .o_rdata(l_rdata));
    sll_ram #(.DEPTH(POOL_SIZE), .WIDTH(DATA_WIDTH)) u_values (
        .i_clk(i_clk), .i_we(v_we), .i_addr(v_addr), .i_wdata(v_wdata), .o_rdata(v_rdata));

    assign i_cmd.ready   = (r_state == S_IDLE);
    assign o_rsp.valid   = r_ovalid;
    assign o_rsp.payload = r_out;

    logic [3:0] op;
    assign op = r_cmd.opcode;

    // Memory port control follows the state.
    always_comb begin
        l_we = 1'b0; l_addr = r_cur; l_wdata = '0;
        v_we = 1'b0; v_addr = r_cur; v_wdata = r_cmd.data_in;
        unique case (r_state)
            S_INIT: begin
                l_we = 1'b1; l_addr = r_cur;
                l_wdata = (r_cur == AW'(POOL_SIZE - 1)) ? '0 : r_cur + AW'(1);
            end
            S_TAKE: l_addr = (r_phase == 2'd3) ? r_tmp : '0;
            S_WR1: begin
                if (op == OP_CREATE) begin
                    l_we = 1'b1; l_addr = '0; l_wdata = r_free;
                end else if (op == OP_DELETE) begin
                    l_we = 1'b1; l_addr = r_prev; l_wdata = l_rdata;
                end else if (op == OP_DESTROY) begin
                    l_we = 1'b1; l_addr = r_cur; l_wdata = r_free;
                end else begin
                    l_we = 1'b1; l_addr = '0; l_wdata = l_rdata;
                end
            end
            S_WR2: begin
                if (op == OP_CREATE) begin
                    l_we = 1'b1; l_addr = r_tmp; l_wdata = '0;
                end else if (op == OP_INSERT) begin
                    l_we = 1'b1; l_addr = r_tmp; l_wdata = r_cur;
                    v_we = 1'b1; v_addr = r_tmp;
                end else if (op == OP_DELETE) begin
                    l_we = 1'b1; l_addr = r_cur; l_wdata = r_free;
                end else begin
                    l_we = 1'b1; l_addr = '0; l_wdata = r_cur;
                end
            end
            S_FREE: begin
                // Insert pops the free list; delete and destroy push r_cur onto it.
                l_we = 1'b1; l_addr = '0; l_wdata = (op == OP_INSERT) ? r_free : r_cur;
            end
            S_VRD: v_addr = r_cur;
            default: ;
        endcase
        if (op == OP_INSERT && r_state == S_WR1) begin
            l_addr = r_prev; l_wdata = r_tmp;
        end
    end

    // Command sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_INIT;
            r_cur    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (o_rsp.valid && o_rsp.ready && r_state != S_DONE) r_ovalid <= 1'b0;
            unique case (r_state)
                S_INIT: begin
                    r_cur <= r_cur + AW'(1);
                    if (r_cur == AW'(POOL_SIZE - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_cmd.valid && i_cmd.ready) begin
                        r_cmd <= i_cmd.payload;
                        r_rsp <= '{status: ST_ERR, new_head: '0, count_out: '0, data_out: '0};
                        r_cnt <= CW'(1);
                        r_steps <= '0;
                        r_phase <= '0;
                        r_prev <= i_cmd.payload.list_head;
                        if (i_cmd.payload.opcode == OP_CREATE) begin
                            r_cur <= '0;
                            r_state <= (i_cmd.payload.list_head == '0) ? S_TAKE : S_DONE;
                            r_tmp <= '0;
                        end else if (i_cmd.payload.opcode == OP_FREECNT) begin
                            r_cur <= '0; r_cnt <= '0;
                            r_state <= S_RD;
                        end else if (i_cmd.payload.opcode > OP_FREECNT ||
                                     i_cmd.payload.list_head == '0) begin
                            r_state <= S_DONE;
                        end else begin
                            r_cur <= i_cmd.payload.list_head;
                            if (i_cmd.payload.opcode == OP_LENGTH ||
                                i_cmd.payload.opcode == OP_DESTROY) r_cnt <= '0;
                            r_state <= S_RD;
                        end
                    end
                end
                S_RD: r_state <= S_WAIT;
                S_WAIT: r_state <= S_STEP;
                S_STEP: begin
                    // l_rdata holds link of r_cur.
                    case (op)
                        OP_FREECNT, OP_LENGTH: begin
                            if (l_rdata == '0) begin
                                r_rsp.status <= ST_OK; r_rsp.count_out <= r_cnt;
                                r_state <= S_DONE;
                            end else begin
                                r_cnt <= r_cnt + CW'(1);
                                r_cur <= l_rdata;
                                r_steps <= r_steps + CW'(1);
                                r_state <= (r_steps == CW'(POOL_SIZE - 1)) ? S_DONE : S_RD;
                                if (r_steps == CW'(POOL_SIZE - 1)) begin
                                    r_rsp.status <= ST_OK;
                                    r_rsp.count_out <= r_cnt + CW'(1);
                                end
                            end
                        end
                        OP_EMPTY: begin
                            r_rsp.status <= ST_OK;
                            r_rsp.count_out <= (l_rdata == '0) ? CW'(1) : '0;
                            r_state <= S_DONE;
                        end
                        OP_DESTROY: begin
                            // Give node r_cur back: read free head, then relink.
                            r_tmp <= l_rdata;
                            r_state <= S_TAKE;
                        end
                        default: begin
                            // Element walk: r_cur is prev candidate, l_rdata the element.
                            if (r_steps == '0 && op != OP_INSERT) begin
                                // first step from head
                            end
                            if (op == OP_INSERT && r_cnt == r_cmd.position) begin
                                r_prev <= r_cur; r_cur <= l_rdata;
                                r_state <= S_TAKE;
                            end else if (l_rdata == '0 || r_steps == CW'(POOL_SIZE)) begin
                                r_state <= S_DONE;
                            end else begin
                                r_prev <= r_cur;
                                r_cur <= l_rdata;
                                r_state <= S_VRD;
                            end
                        end
                    endcase
                end
                S_VRD: r_state <= S_VCHK;
                S_VCHK: begin
                    // v_rdata = value of r_cur, l_rdata = link of r_cur.
                    if (r_phase == 2'd1) begin
                        // value of next element for OP_NEXT
                        r_rsp.status <= ST_OK; r_rsp.data_out <= v_rdata;
                        r_state <= S_DONE;
                    end else if (r_phase == 2'd2) begin
                        r_rsp.status <= ST_OK; r_rsp.data_out <= v_rdata;
                        r_state <= S_DONE;
                    end else if (((op == OP_GET || op == OP_DELETE) &&
                                  r_cnt == r_cmd.position) ||
                                 ((op == OP_LOCATE || op == OP_PRIOR || op == OP_NEXT) &&
                                  v_rdata == r_cmd.data_in)) begin
                        case (op)
                            OP_GET: begin
                                r_rsp.status <= ST_OK; r_rsp.data_out <= v_rdata;
                                r_state <= S_DONE;
                            end
                            OP_LOCATE: begin
                                r_rsp.status <= ST_OK; r_rsp.count_out <= r_cnt;
                                r_state <= S_DONE;
                            end
                            OP_PRIOR: begin
                                if (r_prev == r_cmd.list_head) r_state <= S_DONE;
                                else begin
                                    r_cur <= r_prev; r_phase <= 2'd2; r_state <= S_VRD;
                                end
                            end
                            OP_NEXT: begin
                                if (l_rdata == '0) r_state <= S_DONE;
                                else begin
                                    r_cur <= l_rdata; r_phase <= 2'd1; r_state <= S_VRD;
                                end
                            end
                            default: begin
                                // Delete: unlink r_cur, then return it to the free list.
                                r_rsp.status <= ST_OK; r_rsp.data_out <= v_rdata;
                                r_tmp <= l_rdata;
                                r_state <= S_TAKE;
                            end
                        endcase
                    end else if (r_steps == CW'(POOL_SIZE - 1)) begin
                        r_state <= S_DONE;
                    end else begin
                        r_cnt <= r_cnt + CW'(1);
                        r_steps <= r_steps + CW'(1);
                        r_state <= S_RD;
                    end
                end
                S_TAKE: begin
                    // Read free head link (node 0) or the taken node's link.
                    if (op == OP_DELETE || op == OP_DESTROY) begin
                        r_state <= S_TAKEW;
                    end else begin
                        r_state <= S_TAKEW;
                    end
                end
                S_TAKEW: begin
                    if (op == OP_DELETE || op == OP_DESTROY) begin
                        r_state <= S_WR1;
                    end else if (r_phase == 2'd0) begin
                        // l_rdata = link of node 0 = free head.
                        if (l_rdata == '0) begin
                            r_rsp.status <= ST_FULL; r_state <= S_DONE;
                        end else begin
                            r_tmp <= l_rdata; r_phase <= 2'd3; r_state <= S_TAKE;
                        end
                    end else begin
                        r_state <= S_WR1;
                    end
                end
                S_WR1: begin
                    if (op == OP_DELETE) r_state <= S_WR2;
                    else if (op == OP_DESTROY) r_state <= S_FREE;
                    else r_state <= S_WR2;
                end
                S_WR2: begin
                    r_rsp.status <= ST_OK;
                    if (op == OP_CREATE) r_rsp.new_head <= r_tmp;
                    r_state <= (op == OP_CREATE) ? S_DONE : S_FREE;
                end
                S_FREE: begin
                    if (op == OP_DESTROY) begin
                        r_steps <= r_steps + CW'(1);
                        if (r_tmp == '0 || r_steps == CW'(POOL_SIZE - 1)) begin
                            r_rsp.status <= ST_OK; r_state <= S_DONE;
                        end else begin
                            r_cur <= r_tmp; r_state <= S_RD;
                        end
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_ovalid || o_rsp.ready) begin
                        r_ovalid <= 1'b1;
                        r_out <= r_rsp;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Link captured in S_TAKEW: the free head before a release, or the taken node's link before a take.
    always_ff @(posedge i_clk) begin
        if (r_state == S_TAKEW) r_free <= l_rdata;
    end

    // Checks on the sequencer.
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !i_cmd.ready) else $error("accept while busy");
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> (o_rsp.payload.status != 2'd3)) else $error("bad status");
    a_err_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.payload.status != ST_OK) |->
        (o_rsp.payload.data_out == '0 && o_rsp.payload.count_out == '0))
        else $error("error result carries data");
endmodule

### rtl/sll_ram.sv
// Generic single-port RAM with registered read data.
module sll_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

### verif/tb_top.sv
// Self-checking testbench of the linked list engine with a built-in list pool predictor.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import sll_pkg::*;

    localparam int CYCLE_LIMIT = 20000000;
    localparam int DRAIN_CYCLES = 1200;

    logic i_clk;
    logic i_rst_n;

    sll_cmd_if cmd_ch();
    sll_rsp_if rsp_ch();

    static_linked_list_engine_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch),
        .o_rsp   (rsp_ch)
    );

    // Predicted pool: link of every node and value of every node.
    logic [AW-1:0]         pool_link [POOL_SIZE];
    logic [DATA_WIDTH-1:0] pool_val  [POOL_SIZE];

    t_rsp        pending_rsp [$];
    logic [7:0]  live_heads [$];
    t_rsp        last_rsp;
    int          error_count;
    int          mismatch_count;
    int          cycle_count;
    int          burst_left;
    int          ready_mode;
    int          ready_left;

    // Clock generation.
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Run length guard.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    // Predictor helpers for the free list.
    function automatic logic [AW-1:0] pool_pop();
        logic [AW-1:0] n;
        n = pool_link[0];
        if (n != 0) begin
            pool_link[0] = pool_link[n];
            pool_link[n] = '0;
        end
        return n;
    endfunction

    function automatic void pool_push(logic [AW-1:0] n);
        if (n != 0) begin
            pool_link[n] = pool_link[0];
            pool_link[0] = n;
        end
    endfunction

    // Number of links after a node, bounded by the pool size.
    function automatic int chain_len(logic [AW-1:0] start);
        logic [AW-1:0] cur;
        int cnt;
        cnt = 0;
        cur = pool_link[start];
        for (int s = 0; cur != 0 && s < POOL_SIZE; s++) begin
            cnt++;
            cur = pool_link[cur];
        end
        return cnt;
    endfunction

    // Value of the element at a 1-based position of a list.
    function automatic logic [DATA_WIDTH-1:0] elem_at(logic [AW-1:0] head, int pos);
        logic [AW-1:0] cur;
        cur = pool_link[head];
        for (int k = 1; k < pos; k++) cur = pool_link[cur];
        return pool_val[cur];
    endfunction

    // Executes one command on the predicted pool and returns the expected result.
    function automatic t_rsp engine_exec(t_cmd c);
        t_rsp r;
        logic [AW-1:0] cur, prev, nx, n;
        int cnt, steps, idx;
        logic hit;
        r = '0;
        r.status = ST_ERR;
        cnt = 0;
        if (c.opcode == OP_CREATE) begin
            if (c.list_head == 0) begin
                n = pool_pop();
                if (n == 0) r.status = ST_FULL;
                else begin
                    r.status = ST_OK;
                    r.new_head = n;
                end
            end
        end else if (c.opcode == OP_FREECNT) begin
            cnt = chain_len(0);
            r.status = ST_OK;
        end else if (c.opcode <= OP_DELETE && c.list_head != 0) begin
            case (c.opcode)
                OP_DESTROY: begin
                    cur = c.list_head;
                    for (steps = 0; cur != 0 && steps < POOL_SIZE; steps++) begin
                        nx = pool_link[cur];
                        pool_push(cur);
                        cur = nx;
                    end
                    r.status = ST_OK;
                end
                OP_EMPTY: begin
                    cnt = (pool_link[c.list_head] == 0) ? 1 : 0;
                    r.status = ST_OK;
                end
                OP_LENGTH: begin
                    cnt = chain_len(c.list_head);
                    r.status = ST_OK;
                end
                OP_INSERT: begin
                    prev = c.list_head;
                    cur = pool_link[prev];
                    idx = 1;
                    for (steps = 0; cur != 0 && steps < POOL_SIZE && idx != c.position;
                         steps++) begin
                        prev = cur;
                        cur = pool_link[cur];
                        idx++;
                    end
                    if (idx == c.position && (cur == 0 || steps < POOL_SIZE)) begin
                        n = pool_pop();
                        if (n == 0) r.status = ST_FULL;
                        else begin
                            if (steps >= POOL_SIZE) cur = 0;
                            pool_link[prev] = n;
                            pool_link[n] = cur;
                            pool_val[n] = c.data_in;
                            r.status = ST_OK;
                        end
                    end
                end
                default: begin
                    // Walks for get, locate, prior, next and delete.
                    prev = c.list_head;
                    cur = pool_link[prev];
                    idx = 1;
                    for (steps = 0; cur != 0 && steps < POOL_SIZE; steps++) begin
                        if (c.opcode == OP_GET || c.opcode == OP_DELETE)
                            hit = (idx == c.position);
                        else
                            hit = (pool_val[cur] == c.data_in);
                        if (hit) begin
                            case (c.opcode)
                                OP_GET: begin
                                    r.data_out = pool_val[cur];
                                    r.status = ST_OK;
                                end
                                OP_LOCATE: begin
                                    cnt = idx;
                                    r.status = ST_OK;
                                end
                                OP_PRIOR: begin
                                    if (prev != c.list_head) begin
                                        r.data_out = pool_val[prev];
                                        r.status = ST_OK;
                                    end
                                end
                                OP_NEXT: begin
                                    nx = pool_link[cur];
                                    if (nx != 0) begin
                                        r.data_out = pool_val[nx];
                                        r.status = ST_OK;
                                    end
                                end
                                default: begin
                                    r.data_out = pool_val[cur];
                                    pool_link[prev] = pool_link[cur];
                                    pool_push(cur);
                                    r.status = ST_OK;
                                end
                            endcase
                            break;
                        end
                        prev = cur;
                        cur = pool_link[cur];
                        idx++;
                    end
                end
            endcase
        end
        r.count_out = cnt[8:0];
        if (r.status != ST_OK) begin
            r.count_out = '0;
            r.data_out = '0;
        end
        return r;
    endfunction

    // Sends one command request in bursts with random gaps, then records its prediction.
    task automatic send_cmd(logic [3:0] op, logic [7:0] head, logic [8:0] pos,
                            logic [DATA_WIDTH-1:0] data);
        t_cmd c;
        int gap;
        c.opcode = op;
        c.list_head = head;
        c.position = pos;
        c.data_in = data;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                cmd_ch.valid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        cmd_ch.valid = 1'b1;
        cmd_ch.payload = c;
        do @(posedge i_clk); while (!cmd_ch.ready);
        last_rsp = engine_exec(c);
        pending_rsp.push_back(last_rsp);
        if (op == OP_CREATE && last_rsp.status == ST_OK) live_heads.push_back(last_rsp.new_head);
        @(negedge i_clk);
    endtask

    // Destroys a list and drops it from the set of live lists.
    task automatic drop_list(int slot);
        logic [7:0] h;
        h = live_heads[slot];
        live_heads.delete(slot);
        send_cmd(OP_DESTROY, h, 9'($urandom), $urandom);
    endtask

    // Receiver stall pattern: modes of full, frequent and rare readiness.
    always @(negedge i_clk) begin
        if (ready_left == 0) begin
            ready_mode = $urandom_range(0, 2);
            ready_left = $urandom_range(20, 300);
        end
        ready_left--;
        case (ready_mode)
            0: rsp_ch.ready = 1'b1;
            1: rsp_ch.ready = ($urandom_range(0, 9) < 7);
            default: rsp_ch.ready = ($urandom_range(0, 9) < 2);
        endcase
    end

    // Result checker against the oldest expectation.
    always @(posedge i_clk) begin
        t_rsp exp_r;
        t_rsp got;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            got = rsp_ch.payload;
            if (pending_rsp.size() == 0) begin
                error_count++;
                if (mismatch_count < 10)
                    $display("unexpected result: %p", got);
                mismatch_count++;
            end else begin
                exp_r = pending_rsp.pop_front();
                if (got.status !== exp_r.status || got.new_head !== exp_r.new_head ||
                    got.count_out !== exp_r.count_out || got.data_out !== exp_r.data_out) begin
                    error_count++;
                    if (mismatch_count < 10)
                        $display("mismatch: expected %p, actual %p", exp_r, got);
                    mismatch_count++;
                end
            end
        end
    end

    // Directed pass over every command and each corner of the contract.
    task automatic test_directed();
        logic [7:0] h;
        send_cmd(OP_FREECNT, 8'd0, 9'd0, 32'd0);
        send_cmd(OP_CREATE, 8'd0, 9'd0, 32'd0);
        h = last_rsp.new_head;
        send_cmd(OP_CREATE, 8'hff, 9'h1ff, 32'hffffffff);
        send_cmd(OP_EMPTY, h, 9'd0, 32'd0);
        send_cmd(OP_LENGTH, h, 9'd0, 32'd0);
        send_cmd(OP_GET, h, 9'd1, 32'd0);
        send_cmd(OP_INSERT, h, 9'd0, 32'd5);
        send_cmd(OP_INSERT, h, 9'd1, 32'hffffffff);
        send_cmd(OP_INSERT, h, 9'd2, 32'h0);
        send_cmd(OP_INSERT, h, 9'h1ff, 32'h1234);
        send_cmd(OP_GET, h, 9'd1, 32'd0);
        send_cmd(OP_GET, h, 9'd2, 32'd0);
        send_cmd(OP_LOCATE, h, 9'd0, 32'h0);
        send_cmd(OP_LOCATE, h, 9'd0, 32'h55aa);
        send_cmd(OP_PRIOR, h, 9'd0, 32'hffffffff);
        send_cmd(OP_PRIOR, h, 9'd0, 32'h0);
        send_cmd(OP_NEXT, h, 9'd0, 32'h0);
        send_cmd(OP_NEXT, h, 9'd0, 32'hffffffff);
        send_cmd(OP_DELETE, h, 9'd3, 32'd0);
        send_cmd(OP_DELETE, h, 9'd1, 32'd0);
        send_cmd(4'd11, h, 9'd1, 32'd0);
        send_cmd(4'd15, 8'd0, 9'd0, 32'd0);
        send_cmd(OP_DESTROY, 8'd0, 9'd0, 32'd0);
        send_cmd(OP_GET, 8'd0, 9'd1, 32'd0);
        drop_list(live_heads.size() - 1);
        send_cmd(OP_FREECNT, 8'd0, 9'd0, 32'd0);
    endtask

    // Fills the whole pool through one list, hits exhaustion, then frees it.
    task automatic test_pool_exhaustion();
        logic [7:0] h;
        int len;
        send_cmd(OP_CREATE, 8'd0, 9'd0, 32'd0);
        h = last_rsp.new_head;
        while (chain_len(0) > 0) send_cmd(OP_INSERT, h, 9'd1, $urandom);
        send_cmd(OP_INSERT, h, 9'd1, $urandom);
        send_cmd(OP_CREATE, 8'd0, 9'd0, 32'd0);
        send_cmd(OP_FREECNT, 8'd0, 9'd0, 32'd0);
        len = chain_len(h);
        send_cmd(OP_LENGTH, h, 9'd0, 32'd0);
        send_cmd(OP_GET, h, len[8:0], 32'd0);
        send_cmd(OP_LOCATE, h, 9'd0, elem_at(h, len));
        send_cmd(OP_GET, h, 9'd256, 32'd0);
        send_cmd(OP_DELETE, h, len[8:0], 32'd0);
        send_cmd(OP_INSERT, h, 9'd256, 32'd0);
        drop_list(live_heads.size() - 1);
        send_cmd(OP_FREECNT, 8'd0, 9'd0, 32'd0);
    endtask

    // Random traffic over a handful of live lists.
    task automatic test_random(int n_items);
        int pick, slot, len;
        logic [7:0] h;
        logic [8:0] pos;
        logic [DATA_WIDTH-1:0] d;
        for (int i = 0; i < n_items; i++) begin
            pick = $urandom_range(0, 99);
            slot = (live_heads.size() > 0) ? $urandom_range(0, live_heads.size() - 1) : 0;
            h = (live_heads.size() > 0 && $urandom_range(0, 14) != 0) ? live_heads[slot] : 8'd0;
            len = (h != 0) ? chain_len(h) : 0;
            pos = 9'($urandom);
            if ($urandom_range(0, 4) != 0) pos = 9'($urandom_range(1, len + 1));
            d = ($urandom_range(0, 2) == 0) ? 32'($urandom_range(0, 7)) : 32'($urandom);
            if (h != 0 && len > 0 && $urandom_range(0, 9) < 7)
                d = elem_at(h, $urandom_range(1, len));
            if (live_heads.size() < 2 || pick < 8) begin
                send_cmd(OP_CREATE, ($urandom_range(0, 5) == 0) ? 8'($urandom) : 8'd0,
                         9'($urandom), $urandom);
            end else if (pick < 12) begin
                if (h != 0) drop_list(slot);
                else send_cmd(OP_DESTROY, 8'd0, pos, d);
            end else if (pick < 20) begin
                // Read-only queries may name any node at all.
                send_cmd(($urandom_range(0, 1) == 0) ? OP_EMPTY : OP_LENGTH,
                         ($urandom_range(0, 3) == 0) ? 8'($urandom) : h, pos, d);
            end else if (pick < 32) send_cmd(OP_GET, h, pos, d);
            else if (pick < 42) send_cmd(OP_LOCATE, h, pos, d);
            else if (pick < 49) send_cmd(OP_PRIOR, h, pos, d);
            else if (pick < 56) send_cmd(OP_NEXT, h, pos, d);
            else if (pick < 80) begin
                if (len > 40 && $urandom_range(0, 3) != 0) send_cmd(OP_DELETE, h, pos, d);
                else send_cmd(OP_INSERT, h, pos, d);
            end else if (pick < 94) send_cmd(OP_DELETE, h, pos, d);
            else if (pick < 97) send_cmd(OP_FREECNT, 8'($urandom), pos, d);
            else send_cmd(4'($urandom_range(11, 15)), 8'($urandom), pos, d);
        end
    endtask

    // Test sequence.
    initial begin
        error_count = 0;
        mismatch_count = 0;
        cycle_count = 0;
        burst_left = 0;
        ready_left = 0;
        ready_mode = 0;
        rsp_ch.ready = 1'b0;
        cmd_ch.valid = 1'b0;
        cmd_ch.payload = '0;
        i_rst_n = 1'b0;
        for (int k = 0; k < POOL_SIZE; k++) begin
            pool_link[k] = AW'(k + 1);
            pool_val[k] = '0;
        end
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_pool_exhaustion();
        test_random(760);

        cmd_ch.valid = 1'b0;
        while (pending_rsp.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0 && pending_rsp.size() == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end
endmodule
